// ===== src/pcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and the crc byte step for the cksum crc-32 block.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // one classified item travelling from the front to the back
    typedef struct packed {
        logic [31:0] count;  // byte count after this item (valid on last)
        logic        ovf;    // count has overflowed for this message
        logic        last;   // final byte of the message
        logic        fold;   // byte goes into the crc
        logic [7:0]  data;
    } pcc_item_t;

    typedef enum logic [0:0] {
        ST_DATA,
        ST_LEN
    } pcc_state_t;

    // msb-first crc over one byte, eight shift steps
    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  byte_in);
        logic [31:0] crc;
        crc = crc_in ^ {byte_in, 24'h0};
        for (int b = 0; b < 8; b++) begin
            if (crc[31]) begin
                crc = {crc[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[30:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== src/pcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_front
// Accepts message bytes, keeps the byte count and marks each item.
// ----------------------------------------------------------------------------
module pcc_front
    import pcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_data,
    input  logic        s_last,
    input  logic        q_full,
    output logic        q_push,
    output pcc_item_t   q_item
);

    logic [31:0] count_reg, count_next;
    logic        ovf_reg, ovf_next;
    logic        fold;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        fold       = 1'b0;
        if (!ovf_reg) begin
            if (count_reg == COUNT_MAX) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + 32'd1;
                fold       = 1'b1;
            end
        end
    end

    always_comb begin
        q_item.count = count_next;
        q_item.ovf   = ovf_next;
        q_item.last  = s_last;
        q_item.fold  = fold;
        q_item.data  = s_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (q_push) begin
            // the count starts again with the next message
            if (s_last) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else begin
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // once overflowed, the count stays saturated until the message ends
    a_ovf_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> count_reg == COUNT_MAX)
        else $error("overflow flag set with unsaturated count");

endmodule

// ===== src/pcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module pcc_queue
    import pcc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pcc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output pcc_item_t head_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    pcc_item_t     mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push, do_pop;

    assign full      = cnt_reg == DEPTH_CNT;
    assign valid     = cnt_reg != '0;
    assign head_item = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= DEPTH_CNT)
        else $error("queue fill beyond depth");

endmodule

// ===== src/pcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_back
// Crc engine: folds data bytes, appends the length and registers the result;
// an overflowed message gives checksum 0 with the overflow flag instead.
module pcc_back
    import pcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  pcc_item_t   q_item,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_checksum,
    output logic        m_overflow
);

    pcc_state_t  state_reg, state_next;
    logic [31:0] crc_reg;
    logic [31:0] len_reg;
    logic        out_valid_reg;
    logic [31:0] checksum_reg;
    logic        ovf_out_reg;
    logic        out_free;
    logic        emit;

    assign out_free   = !out_valid_reg || m_tready;
    assign m_tvalid   = out_valid_reg;
    assign m_checksum = checksum_reg;
    assign m_overflow = ovf_out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_DATA: begin
                if (q_pop && q_item.last && !q_item.ovf) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (len_reg == '0 && out_free) begin
                    state_next = ST_DATA;
                end
            end
            default: state_next = ST_DATA;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop = 1'b0;
        emit  = 1'b0;
        case (state_reg)
            ST_DATA: begin
                // an overflowed last item emits straight away, so needs the slot
                q_pop = q_valid && (!q_item.last || !q_item.ovf || out_free);
                emit  = q_pop && q_item.last && q_item.ovf;
            end
            ST_LEN: begin
                emit = (len_reg == '0) && out_free;
            end
            default: begin
                q_pop = 1'b0;
                emit  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_DATA;
            crc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_DATA) begin
                if (q_pop) begin
                    if (q_item.last && q_item.ovf) begin
                        crc_reg <= '0;
                    end else if (q_item.fold) begin
                        crc_reg <= fold_byte(crc_reg, q_item.data);
                    end
                end
            end else if (len_reg != '0) begin
                crc_reg <= fold_byte(crc_reg, len_reg[7:0]);
            end else if (emit) begin
                crc_reg <= '0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DATA) begin
            if (q_pop && q_item.last) begin
                len_reg <= q_item.count;
            end
        end else if (len_reg != '0) begin
            len_reg <= len_reg >> 8;
        end
        if (emit) begin
            if (state_reg == ST_LEN) begin
                checksum_reg <= ~crc_reg;
                ovf_out_reg  <= 1'b0;
            end else begin
                checksum_reg <= '0;
                ovf_out_reg  <= 1'b1;
            end
        end
    end

    // the length is appended one byte a cycle, low byte first
    a_len_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEN && len_reg != '0) |=> len_reg == ($past(len_reg) >> 8))
        else $error("length not shifted by one byte");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && ovf_out_reg) |-> checksum_reg == '0)
        else $error("overflowed result with nonzero checksum");

endmodule

// ===== src/posix_cksum_crc32_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// posix_cksum_crc32_top
// Posix cksum crc-32 over a byte stream with the byte count appended.
// ----------------------------------------------------------------------------
// Message bytes are taken one per cycle while the queue is not full; the front
// counts them and hands each item through a QUEUE_DEPTH-entry queue to the crc
// engine, which folds one byte per cycle while items wait and it takes data. After
// the last byte of a message the engine folds in the length low byte first, up to
// its highest nonzero byte (one to four bytes), then registers the result once the
// output slot is free; the queue lets the next message stream in meanwhile.
// A message whose count passes 2^32-1 yields checksum 0 with the overflow flag.
module posix_cksum_crc32_top
    import pcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] checksum
    output logic        m_tuser    // [0] length_overflow
);

    pcc_item_t front_item;
    pcc_item_t head_item;
    logic      q_push, q_full, q_pop, q_valid;

    pcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_data   (s_tdata),
        .s_last   (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (front_item)
    );

    pcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_item (head_item)
    );

    pcc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (head_item),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_checksum (m_tdata),
        .m_overflow (m_tuser)
    );

endmodule
